// ===== rtl/core/point_segment_distance_top_defines.svh =====
// Assertion macros for the point to segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSD_ASSERT(label, prop, msg)
`define PSD_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/core/psd_pkg.sv =====
// Types and constants for the point to segment distance block.
package psd_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_BITS   = 16;
  localparam int DIST_BITS  = 17;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int LEN_W  = PROD_W;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int TC_W   = T_W + 1 + DIFF_W;
  localparam int E_W    = FRAC_BITS + COORD_BITS + 3;
  localparam int OFF_W  = COORD_BITS + 5;
  localparam int SQ_W   = 2 * OFF_W;
  localparam int RAD_W  = (SQ_W + 1) + ((SQ_W + 1) % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int RREM_W = ROOT_W + 2;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [TOL_BITS-1:0]  TOL_RESET = TOL_BITS'(32);

  // projection parameter source
  localparam logic [1:0] T_ZERO = 2'd0;
  localparam logic [1:0] T_ONE  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 hit;
    logic                 degenerate;
  } psd_out_t;
endpackage

// ===== rtl/core/point_segment_distance_top.sv =====
// Point to segment distance top level: pipelined projection, divider and square root.
// Fully pipelined: one word accepted per clock while the output register is empty or being
// taken. The pipe holds the bit-per-stage divider for the projection
// parameter and the bit-per-stage integer square root. The whole pipe advances when the
// output register is empty or being taken, so in_ready follows out_ready through one gate.
// The tolerance register tol is sampled as words leave the pipe.
`include "point_segment_distance_top_defines.svh"
module point_segment_distance_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  psd_pkg::psd_in_t               in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output psd_pkg::psd_out_t              out_word,
  input  logic                           cfg_we,
  input  logic [psd_pkg::TOL_BITS-1:0]   cfg_wdata
);
  import psd_pkg::*;

  typedef struct packed {
    logic                     v;
    logic [LEN_W-1:0]         rem;
    logic [LEN_W-1:0]         len;
    logic [FRAC_BITS-1:0]     q;
    logic [1:0]               mode;
    logic                     degen;
    logic signed [DIFF_W-1:0] a;
    logic signed [DIFF_W-1:0] b;
    logic signed [DIFF_W-1:0] c;
    logic signed [DIFF_W-1:0] d;
  } div_st_t;

  typedef struct packed {
    logic              v;
    logic [RREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic              degen;
  } sqrt_st_t;

  logic en;
  logic [TOL_BITS-1:0] tol;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // stage 1: differences
  logic s1_v;
  logic signed [DIFF_W-1:0] s1_a, s1_b, s1_c, s1_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_a <= DIFF_W'(in_word.query_x) - DIFF_W'(in_word.start_x);
      s1_b <= DIFF_W'(in_word.query_y) - DIFF_W'(in_word.start_y);
      s1_c <= DIFF_W'(in_word.end_x) - DIFF_W'(in_word.start_x);
      s1_d <= DIFF_W'(in_word.end_y) - DIFF_W'(in_word.start_y);
    end
  end

  // stage 2: products
  logic s2_v;
  logic signed [PROD_W-1:0] s2_ac, s2_bd, s2_cc, s2_dd;
  logic signed [DIFF_W-1:0] s2_a, s2_b, s2_c, s2_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_ac <= s1_a * s1_c;
      s2_bd <= s1_b * s1_d;
      s2_cc <= s1_c * s1_c;
      s2_dd <= s1_d * s1_d;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_c  <= s1_c;
      s2_d  <= s1_d;
    end
  end

  // stage 3: dot product, squared length, clamp decision
  logic signed [SUM_W-1:0] dot;
  logic [SUM_W-1:0]        len_sum;
  logic [1:0]              mode;
  assign dot     = SUM_W'(s2_ac) + SUM_W'(s2_bd);
  assign len_sum = SUM_W'(s2_cc) + SUM_W'(s2_dd);

  always_comb begin
    if (len_sum == '0 || dot[SUM_W-1] || dot == '0) begin
      mode = T_ZERO;
    end else if (dot >= $signed(len_sum)) begin
      mode = T_ONE;
    end else begin
      mode = T_DIV;
    end
  end

  div_st_t dv0;
  always_ff @(posedge clk) begin
    if (rst) begin
      dv0.v <= 1'b0;
    end else if (en) begin
      dv0.v <= s2_v;
    end
    if (en) begin
      dv0.rem   <= LEN_W'(dot);
      dv0.len   <= LEN_W'(len_sum);
      dv0.q     <= '0;
      dv0.mode  <= mode;
      dv0.degen <= (len_sum == '0);
      dv0.a     <= s2_a;
      dv0.b     <= s2_b;
      dv0.c     <= s2_c;
      dv0.d     <= s2_d;
    end
  end

  // restoring divider, one quotient bit per stage
  div_st_t dr [FRAC_BITS];
  genvar gi;
  generate
    for (gi = 0; gi < FRAC_BITS; gi++) begin : g_div
      div_st_t          src;
      logic [LEN_W:0]   shl;
      logic             ge;
      if (gi == 0) begin : g_first
        assign src = dv0;
      end else begin : g_next
        assign src = dr[gi-1];
      end
      assign shl = {src.rem, 1'b0};
      assign ge  = shl >= {1'b0, src.len};
      always_ff @(posedge clk) begin
        if (rst) begin
          dr[gi].v <= 1'b0;
        end else if (en) begin
          dr[gi].v <= src.v;
        end
        if (en) begin
          dr[gi].rem   <= ge ? LEN_W'(shl - {1'b0, src.len}) : LEN_W'(shl);
          dr[gi].q     <= {src.q[FRAC_BITS-2:0], ge};
          dr[gi].len   <= src.len;
          dr[gi].mode  <= src.mode;
          dr[gi].degen <= src.degen;
          dr[gi].a     <= src.a;
          dr[gi].b     <= src.b;
          dr[gi].c     <= src.c;
          dr[gi].d     <= src.d;
        end
      end
    end
  endgenerate

  // stage: t times segment vector
  div_st_t dq;
  logic [T_W-1:0] t;
  assign dq = dr[FRAC_BITS-1];
  always_comb begin
    unique case (dq.mode)
      T_ONE:   t = T_W'(1) << FRAC_BITS;
      T_DIV:   t = {1'b0, dq.q};
      default: t = '0;
    endcase
  end

  logic s4_v, s4_degen;
  logic signed [TC_W-1:0]   s4_tc, s4_td;
  logic signed [DIFF_W-1:0] s4_a, s4_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= dq.v;
    end
    if (en) begin
      s4_tc    <= $signed({1'b0, t}) * dq.c;
      s4_td    <= $signed({1'b0, t}) * dq.d;
      s4_a     <= dq.a;
      s4_b     <= dq.b;
      s4_degen <= dq.degen;
    end
  end

  // stage: offset magnitudes truncated to 4 fraction bits
  logic signed [E_W-1:0] ex, ey;
  logic [E_W-1:0]        mx, my;
  assign ex = ($signed(E_W'(s4_a)) <<< FRAC_BITS) - E_W'(s4_tc);
  assign ey = ($signed(E_W'(s4_b)) <<< FRAC_BITS) - E_W'(s4_td);
  assign mx = ex[E_W-1] ? E_W'(-ex) : E_W'(ex);
  assign my = ey[E_W-1] ? E_W'(-ey) : E_W'(ey);

  logic s5_v, s5_degen;
  logic [OFF_W-1:0] s5_dx, s5_dy;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
    if (en) begin
      s5_dx    <= mx[FRAC_BITS-4 +: OFF_W];
      s5_dy    <= my[FRAC_BITS-4 +: OFF_W];
      s5_degen <= s4_degen;
    end
  end

  logic s6_v, s6_degen;
  logic [SQ_W-1:0] s6_xx, s6_yy;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
    if (en) begin
      s6_xx    <= s5_dx * s5_dx;
      s6_yy    <= s5_dy * s5_dy;
      s6_degen <= s5_degen;
    end
  end

  sqrt_st_t sq0;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq0.v <= 1'b0;
    end else if (en) begin
      sq0.v <= s6_v;
    end
    if (en) begin
      sq0.rad   <= RAD_W'(s6_xx) + RAD_W'(s6_yy);
      sq0.rem   <= '0;
      sq0.root  <= '0;
      sq0.degen <= s6_degen;
    end
  end

  // digit-by-digit square root, one root bit per stage
  sqrt_st_t sr [ROOT_W];
  generate
    for (gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
      sqrt_st_t          src;
      logic [RREM_W+1:0] r2;
      logic [RREM_W+1:0] trial;
      logic              ge;
      if (gi == 0) begin : g_first
        assign src = sq0;
      end else begin : g_next
        assign src = sr[gi-1];
      end
      assign r2    = {src.rem, src.rad[RAD_W-1 -: 2]};
      assign trial = (RREM_W + 2)'({src.root, 2'b01});
      assign ge    = r2 >= trial;
      always_ff @(posedge clk) begin
        if (rst) begin
          sr[gi].v <= 1'b0;
        end else if (en) begin
          sr[gi].v <= src.v;
        end
        if (en) begin
          sr[gi].rem   <= ge ? RREM_W'(r2 - trial) : RREM_W'(r2);
          sr[gi].root  <= {src.root[ROOT_W-2:0], ge};
          sr[gi].rad   <= {src.rad[RAD_W-3:0], 2'b00};
          sr[gi].degen <= src.degen;
        end
      end
    end
  endgenerate

  // output register
  sqrt_st_t sl;
  logic [ROOT_W-5:0]    dist_full;
  logic [DIST_BITS-1:0] dist_sat;
  assign sl        = sr[ROOT_W-1];
  assign dist_full = sl.root[ROOT_W-1:4];
  assign dist_sat  = (dist_full > (ROOT_W-4)'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(dist_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sl.v;
    end
    if (en) begin
      out_word.distance   <= dist_sat;
      out_word.hit        <= dist_sat <= DIST_BITS'(tol);
      out_word.degenerate <= sl.degen;
    end
  end

  `PSD_ASSERT(a_hit_within_tol, out_valid && out_word.hit |-> out_word.distance <= DIST_BITS'(tol), "hit word beyond tolerance")
  `PSD_ASSERT(a_accept_enters, in_valid && in_ready |=> s1_v, "accepted word lost at entry")
  `PSD_ASSERT(a_stall_holds_out, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled word changed")
  `PSD_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !s1_v, "pipe not empty after reset")
endmodule

// ===== test/tb.sv =====
// Testbench for the point to segment distance block: random and directed words, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  psd_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psd_out_t out_word;
  logic cfg_we = 1'b0;
  logic [TOL_BITS-1:0] cfg_wdata = '0;

  psd_in_t pending_words[$];
  psd_out_t expected_dist[$];
  logic [TOL_BITS-1:0] tolerance = TOL_RESET;
  int errors = 0;
  int sent = 0;
  int taken = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hits = 0;
  int degens = 0;

  always #1 clk = ~clk;

  point_segment_distance_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] offset_mag(longint a, longint c, longint t);
    longint e;
    e = a * (longint'(1) << FRAC_BITS) - t * c;
    if (e < 0) e = -e;
    return 64'(e) >> (FRAC_BITS - 4);
  endfunction

  function automatic psd_out_t closest_distance(psd_in_t w, logic [TOL_BITS-1:0] tol);
    psd_out_t r;
    longint a, b, c, d, dot, len_sq, t;
    logic [63:0] dx, dy, dist_fl;
    a = longint'(w.query_x) - longint'(w.start_x);
    b = longint'(w.query_y) - longint'(w.start_y);
    c = longint'(w.end_x) - longint'(w.start_x);
    d = longint'(w.end_y) - longint'(w.start_y);
    dot = a * c + b * d;
    len_sq = c * c + d * d;
    if (len_sq == 0 || dot <= 0) t = 0;
    else if (dot >= len_sq) t = longint'(1) << FRAC_BITS;
    else t = (dot << FRAC_BITS) / len_sq;
    dx = offset_mag(a, c, t);
    dy = offset_mag(b, d, t);
    dist_fl = int_sqrt(dx * dx + dy * dy) >> 4;
    if (dist_fl > 64'(DIST_MAX)) dist_fl = 64'(DIST_MAX);
    r.distance = dist_fl[DIST_BITS-1:0];
    r.hit = (dist_fl <= 64'(tol));
    r.degenerate = (len_sq == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("tb: mismatch on word %0d %s: got %0d want %0d", taken, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) sent++;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word <= pending_words[0];
        expected_dist = {expected_dist, closest_distance(pending_words[0], tolerance)};
        void'(pending_words.pop_front());
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_dist.size() == 0) begin
          $display("tb: unexpected word");
          errors++;
        end else begin
          if (out_word.distance !== expected_dist[0].distance)
            report("distance", out_word.distance, expected_dist[0].distance);
          if (out_word.hit !== expected_dist[0].hit)
            report("hit", out_word.hit, expected_dist[0].hit);
          if (out_word.degenerate !== expected_dist[0].degenerate)
            report("degenerate", out_word.degenerate, expected_dist[0].degenerate);
          hits += out_word.hit;
          degens += out_word.degenerate;
          void'(expected_dist.pop_front());
        end
        taken++;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  task automatic set_tolerance(logic [TOL_BITS-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = v;
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_dist.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic psd_in_t make_word(int qx, int qy, int sx, int sy, int ex, int ey);
    psd_in_t w;
    w.query_x = 16'(qx); w.query_y = 16'(qy);
    w.start_x = 16'(sx); w.start_y = 16'(sy);
    w.end_x = 16'(ex); w.end_y = 16'(ey);
    return w;
  endfunction

  task automatic add_word(psd_in_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic queue_random(int n, int near);
    psd_in_t w;
    for (int i = 0; i < n; i++) begin
      w = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      if (near != 0 && $urandom_range(0, 1) == 1) begin
        // query close to the segment so hit flips around the tolerance
        w.query_x = w.start_x + 16'($urandom_range(0, 63)) - 16'sd32;
        w.query_y = w.start_y + 16'($urandom_range(0, 63)) - 16'sd32;
      end
      if ($urandom_range(0, 15) == 0) begin
        w.end_x = w.start_x;
        w.end_y = w.start_y;
      end
      add_word(w);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, clamps, zero length
    add_word(make_word(0, 0, 0, 0, 0, 0));
    add_word(make_word(32767, 32767, -32768, -32768, -32768, -32768));
    add_word(make_word(-32768, -32768, 32767, 32767, 32767, 32767));
    add_word(make_word(-32768, 32767, 32767, -32768, 32767, -32767));
    add_word(make_word(16, 32, 0, 0, 160, 0));
    add_word(make_word(-16, 16, 0, 0, 160, 0));
    add_word(make_word(200, 16, 0, 0, 160, 0));
    add_word(make_word(80, 32, 0, 0, 160, 0));
    add_word(make_word(80, 33, 0, 0, 160, 0));
    add_word(make_word(5, 7, 1, 2, 1, 2));
    add_word(make_word(0, 0, -32768, 32767, 32767, -32768));
    add_word(make_word(-1, -1, -32768, -32768, 32767, 32767));
    add_word(make_word(1, 0, 0, 0, 3, 1));
    queue_random(60, 1);
    wait_idle();

    set_tolerance(16'hffff);
    queue_random(100, 0);
    wait_idle();
    set_tolerance(16'h0000);
    queue_random(80, 1);
    wait_idle();
    set_tolerance(16'($urandom_range(1, 200)));
    queue_random(160, 1);
    wait_idle();

    $display("tb: %0d words sent, %0d checked, %0d hits, %0d zero length",
             sent, taken, hits, degens);
    $display("tb: four tolerance settings, random stalls on both sides");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule
